// ===== rtl/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY_RST = 8'h31;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  localparam int unsigned TPROD_W = 31;
  localparam int unsigned HPROD_W = 30;

  typedef struct packed {
    logic [TPROD_W-1:0] temp_prod;
    logic [HPROD_W-1:0] hum_prod;
    logic [15:0]        temp_word;
    logic [15:0]        hum_word;
    status_e            status;
  } scale_req_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(y / 65535) for y below 32768 * 65535, so that the quotient fits in 15 bits
  function automatic logic [14:0] div_by_65535(input logic [TPROD_W-1:0] y);
    logic [31:0] s;
    s = {1'b0, y} + {17'b0, y[30:16]} + 32'd1;
    return s[30:16];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
`default_nettype none

// Decodes six-byte temperature/humidity frames (temperature high, low, CRC, humidity
// high, low, CRC), checking each word with a CRC-8 (init 0xFF, MSB first, polynomial
// from cfg_wdata_i, reset 0x31). One byte is accepted per cycle while in_ready_o is high;
// the CRC update and the constant-scale multiply are combinational, so the sustained rate
// is one byte per clock while the output does not stall. The scaling products of a frame
// are registered in req_q with its sixth byte; htfd_scale then divides them by 65535 and
// applies the temperature offset into its output register once that register is free.
// frame_start_i restarts a frame and drops any partial one. Write the polynomial only while
// no frame is in flight.
module humidity_temp_frame_decoder_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          frame_start_i,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [15:0]        temperature_word_o,
  output logic [15:0]        humidity_word_o,
  output logic [1:0]         frame_status_o
);

  logic [7:0]  poly_q;
  logic [2:0]  pos_d, pos_q;
  logic [7:0]  crc_d, crc_q;
  logic [15:0] temp_d, temp_q;
  logic [7:0]  hum_hi_d, hum_hi_q;
  logic [7:0]  hum_lo_d, hum_lo_q;
  logic        temp_good_d, temp_good_q;
  logic [2:0]  pos;
  logic [7:0]  crc_base;
  logic        restart;
  logic        in_xfer;
  logic        frame_done;
  logic [15:0] hum_word;

  logic                 req_valid_q;
  logic                 req_ready;
  logic                 stage_ready;
  htfd_pkg::scale_req_t req_d, req_q;

  assign stage_ready = !req_valid_q || req_ready;
  assign in_ready_o  = stage_ready;
  assign in_xfer     = in_valid_i && in_ready_o;

  always_comb begin
    restart     = frame_start_i || (pos_q > htfd_pkg::POS_HUM_CRC);
    pos         = restart ? htfd_pkg::POS_TEMP_HI : pos_q;
    crc_base    = restart ? htfd_pkg::CRC_INIT : crc_q;
    pos_d       = pos + 3'd1;
    crc_d       = crc_base;
    temp_d      = temp_q;
    hum_hi_d    = hum_hi_q;
    hum_lo_d    = hum_lo_q;
    temp_good_d = temp_good_q;
    frame_done  = 1'b0;
    hum_word    = {hum_hi_q, hum_lo_q};
    unique case (pos)
      htfd_pkg::POS_TEMP_HI: begin
        temp_d = {data_byte_i, temp_q[7:0]};
        crc_d  = htfd_pkg::crc8_update(crc_base, data_byte_i, poly_q);
      end
      htfd_pkg::POS_TEMP_LO: begin
        temp_d = {temp_q[15:8], data_byte_i};
        crc_d  = htfd_pkg::crc8_update(crc_base, data_byte_i, poly_q);
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_good_d = (crc_base == data_byte_i);
        crc_d       = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_HI: begin
        hum_hi_d = data_byte_i;
        crc_d    = htfd_pkg::crc8_update(crc_base, data_byte_i, poly_q);
      end
      htfd_pkg::POS_HUM_LO: begin
        hum_lo_d = data_byte_i;
        crc_d    = htfd_pkg::crc8_update(crc_base, data_byte_i, poly_q);
      end
      default: begin
        frame_done = 1'b1;
        crc_d      = htfd_pkg::CRC_INIT;
        pos_d      = htfd_pkg::POS_TEMP_HI;
      end
    endcase

    req_d.temp_prod = htfd_pkg::TPROD_W'(temp_q) * htfd_pkg::TPROD_W'(htfd_pkg::TEMP_SCALE);
    req_d.hum_prod  = htfd_pkg::HPROD_W'(hum_word) * htfd_pkg::HPROD_W'(htfd_pkg::HUM_SCALE);
    req_d.temp_word = temp_q;
    req_d.hum_word  = hum_word;
    if (!temp_good_q) begin
      req_d.status = htfd_pkg::STATUS_TEMP_CRC;
    end else if (crc_base != data_byte_i) begin
      req_d.status = htfd_pkg::STATUS_HUM_CRC;
    end else begin
      req_d.status = htfd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= htfd_pkg::CRC_POLY_RST;
      pos_q       <= htfd_pkg::POS_TEMP_HI;
      crc_q       <= htfd_pkg::CRC_INIT;
      temp_q      <= 16'd0;
      hum_hi_q    <= 8'd0;
      hum_lo_q    <= 8'd0;
      temp_good_q <= 1'b0;
      req_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        pos_q       <= pos_d;
        crc_q       <= crc_d;
        temp_q      <= temp_d;
        hum_hi_q    <= hum_hi_d;
        hum_lo_q    <= hum_lo_d;
        temp_good_q <= temp_good_d;
      end
      if (stage_ready) begin
        req_valid_q <= in_xfer && frame_done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_done) begin
      req_q <= req_d;
    end
  end

  htfd_scale u_scale (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (req_valid_q),
    .req_i              (req_q),
    .req_ready_o        (req_ready),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o),
    .temperature_word_o (temperature_word_o),
    .humidity_word_o    (humidity_word_o),
    .frame_status_o     (frame_status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/htfd_scale.sv =====
`default_nettype none

module htfd_scale (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  input  wire htfd_pkg::scale_req_t req_i,
  output logic                      req_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [14:0]        temperature_centi_o,
  output logic [13:0]               humidity_centi_o,
  output logic [15:0]               temperature_word_o,
  output logic [15:0]               humidity_word_o,
  output logic [1:0]                frame_status_o
);

  logic              out_valid_q;
  logic [14:0]       temp_scaled;
  logic [14:0]       hum_scaled;
  logic signed [14:0] temp_centi_d, temp_centi_q;
  logic [13:0]       hum_centi_d, hum_centi_q;
  logic [15:0]       temp_word_q;
  logic [15:0]       hum_word_q;
  htfd_pkg::status_e status_q;

  assign req_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    temp_scaled  = htfd_pkg::div_by_65535(req_i.temp_prod);
    hum_scaled   = htfd_pkg::div_by_65535({1'b0, req_i.hum_prod});
    temp_centi_d = signed'(temp_scaled - htfd_pkg::TEMP_OFFSET);
    hum_centi_d  = hum_scaled[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      out_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      temp_centi_q <= temp_centi_d;
      hum_centi_q  <= hum_centi_d;
      temp_word_q  <= req_i.temp_word;
      hum_word_q   <= req_i.hum_word;
      status_q     <= req_i.status;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_centi_q;
  assign humidity_centi_o    = hum_centi_q;
  assign temperature_word_o  = temp_word_q;
  assign humidity_word_o     = hum_word_q;
  assign frame_status_o      = status_q;

endmodule

`default_nettype wire

// ===== verif/tb_humidity_temp_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_unit;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } frame_byte_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        temp_word;
    logic [15:0]        hum_word;
    htfd_pkg::status_e  status;
  } reading_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i   = 8'h00;
  logic               frame_start_i = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [7:0]         cfg_wdata_i   = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [14:0] temperature_centi_o;
  logic [13:0]        humidity_centi_o;
  logic [15:0]        temperature_word_o;
  logic [15:0]        humidity_word_o;
  logic [1:0]         frame_status_o;

  humidity_temp_frame_decoder_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .frame_start_i      (frame_start_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o),
    .temperature_word_o (temperature_word_o),
    .humidity_word_o    (humidity_word_o),
    .frame_status_o     (frame_status_o)
  );

  // stimulus and expectations
  frame_byte_t pending_bytes[$];
  reading_t    expected_readings[$];
  frame_byte_t staged_byte;
  int          bytes_queued    = 0;
  int          bytes_accepted  = 0;
  int          readings_seen   = 0;
  int          temp_crc_fails  = 0;
  int          hum_crc_fails   = 0;
  int          poly_settings   = 1;
  int          mismatches      = 0;
  int          idle_pct        = 20;
  int          stall_pct       = 20;
  int          send_gap        = 0;
  int          stall_gap       = 0;

  // decoder shadow state
  logic [7:0]  crc_poly        = htfd_pkg::CRC_POLY_RST;
  logic [2:0]  frame_pos       = htfd_pkg::POS_TEMP_HI;
  logic [7:0]  word_crc        = htfd_pkg::CRC_INIT;
  logic [15:0] temp_word_q     = 16'h0000;
  logic [7:0]  hum_hi_q        = 8'h00;
  logic [7:0]  hum_lo_q        = 8'h00;
  logic        temp_ok         = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bit-serial CRC-8, MSB first
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b, logic [7:0] gen);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ gen;
      end
    end
    return crc;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start);
    logic [2:0]       pos;
    reading_t         r;
    longint unsigned  tscaled;
    longint unsigned  hscaled;
    longint           tc;
    logic [15:0]      hw;
    logic             hum_ok;
    pos = frame_pos;
    if (start || pos > htfd_pkg::POS_HUM_CRC) begin
      pos      = htfd_pkg::POS_TEMP_HI;
      word_crc = htfd_pkg::CRC_INIT;
    end
    case (pos)
      htfd_pkg::POS_TEMP_HI: begin
        temp_word_q[15:8] = b;
        word_crc = crc_step(word_crc, b, crc_poly);
      end
      htfd_pkg::POS_TEMP_LO: begin
        temp_word_q[7:0] = b;
        word_crc = crc_step(word_crc, b, crc_poly);
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_ok  = (word_crc == b);
        word_crc = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_HI: begin
        hum_hi_q = b;
        word_crc = crc_step(word_crc, b, crc_poly);
      end
      htfd_pkg::POS_HUM_LO: begin
        hum_lo_q = b;
        word_crc = crc_step(word_crc, b, crc_poly);
      end
      default: begin
        hum_ok  = (word_crc == b);
        hw      = {hum_hi_q, hum_lo_q};
        tscaled = (longint'(temp_word_q) * 17500) / 65535;
        hscaled = (longint'(hw) * 10000) / 65535;
        tc      = longint'(tscaled) - 4500;
        r.temp_centi = tc[14:0];
        r.hum_centi  = hscaled[13:0];
        r.temp_word  = temp_word_q;
        r.hum_word   = hw;
        if (!temp_ok) begin
          r.status = htfd_pkg::STATUS_TEMP_CRC;
          temp_crc_fails++;
        end else if (!hum_ok) begin
          r.status = htfd_pkg::STATUS_HUM_CRC;
          hum_crc_fails++;
        end else begin
          r.status = htfd_pkg::STATUS_OK;
        end
        expected_readings.push_back(r);
        word_crc = htfd_pkg::CRC_INIT;
      end
    endcase
    frame_pos = (pos == htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_HI : pos + 3'd1;
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic start);
    frame_byte_t fb;
    fb.data  = b;
    fb.start = start;
    pending_bytes.push_back(fb);
    bytes_queued++;
  endfunction

  function automatic void queue_frame(logic [15:0] tw, logic [15:0] hw, logic start,
                                      bit spoil_t, bit spoil_h);
    logic [7:0] tcrc;
    logic [7:0] hcrc;
    tcrc = crc_step(crc_step(htfd_pkg::CRC_INIT, tw[15:8], crc_poly), tw[7:0], crc_poly);
    hcrc = crc_step(crc_step(htfd_pkg::CRC_INIT, hw[15:8], crc_poly), hw[7:0], crc_poly);
    if (spoil_t) tcrc = tcrc ^ 8'($urandom_range(1, 255));
    if (spoil_h) hcrc = hcrc ^ 8'($urandom_range(1, 255));
    queue_byte(tw[15:8], start);
    queue_byte(tw[7:0], 1'b0);
    queue_byte(tcrc, 1'b0);
    queue_byte(hw[15:8], 1'b0);
    queue_byte(hw[7:0], 1'b0);
    queue_byte(hcrc, 1'b0);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3)) ^ {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void queue_random_phase(int target);
    int  count;
    int  n;
    int  r;
    bit  need_start;
    count      = 0;
    need_start = 1'b1;
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        queue_frame(pick_word(), pick_word(), need_start | 1'($urandom_range(0, 1)),
                    $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        need_start = 1'b0;
        count += 6;
      end else if (r < 88) begin
        // broken frame: cut short, next frame resyncs
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom_range(0, 255)),
                     (i == 0) ? (need_start | 1'($urandom_range(0, 1))) : 1'b0);
        end
        need_start = 1'b1;
        count += n;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        need_start = 1'b1;
        count += n;
      end
    end
  endfunction

  task automatic drain();
    while (bytes_accepted != bytes_queued || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_poly(logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    crc_poly     = value;
    poly_settings++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      $error("unexpected reading: temperature_word %0h humidity_word %0h",
             temperature_word_o, humidity_word_o);
      mismatches++;
    end else begin
      want = expected_readings.pop_front();
      readings_seen++;
      check_field("temperature_centi", want.temp_centi, temperature_centi_o);
      check_field("humidity_centi", want.hum_centi, humidity_centi_o);
      check_field("temperature_word", want.temp_word, temperature_word_o);
      check_field("humidity_word", want.hum_word, humidity_word_o);
      check_field("frame_status", want.status, frame_status_o);
    end
  endfunction

  // byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i, frame_start_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(0, 4);
            in_valid_i <= 1'b0;
          end else begin
            staged_byte = pending_bytes.pop_front();
            in_valid_i    <= 1'b1;
            data_byte_i   <= staged_byte.data;
            frame_start_i <= staged_byte.start;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // reading monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_reading();
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready_i <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] polys[6];
    int         idle_by_phase[6];
    int         stall_by_phase[6];
    polys          = '{8'h00, 8'hFF, 8'h07, 8'h00, 8'h00, htfd_pkg::CRC_POLY_RST};
    polys[3]       = 8'($urandom_range(0, 255));
    polys[4]       = 8'($urandom_range(0, 255));
    idle_by_phase  = '{25, 0, 40, 10, 25, 0};
    stall_by_phase = '{30, 15, 0, 40, 20, 0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset polynomial, extreme words, status precedence, resync
    queue_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    queue_frame(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_frame(16'h0001, 16'hFFFE, 1'b1, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_poly(polys[p]);
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      queue_random_phase(210);
      drain();
    end
    repeat (10) @(posedge clk_i);

    $display("Checked %0d readings from %0d bytes across %0d CRC polynomials",
             readings_seen, bytes_accepted, poly_settings);
    $display("  temperature CRC failures %0d, humidity CRC failures %0d",
             temp_crc_fails, hum_crc_fails);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("[humidity_temp_frame_decoder_unit] OK");
    end else begin
      $display("[humidity_temp_frame_decoder_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[humidity_temp_frame_decoder_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/htfd_pkg.sv
rtl/htfd_scale.sv
rtl/humidity_temp_frame_decoder_unit.sv
verif/tb_humidity_temp_frame_decoder_unit.sv
